// File: sv/mle_pkg.sv
// Package for the min-label edge relax block.
// Holds action codes, field widths and the item, result and memory-command structs.
// Depends on nothing.
package mle_pkg;

    localparam int VTX_W = 16;
    localparam int LBL_W = 16;
    localparam int ACT_W = 2;

    localparam logic [ACT_W-1:0] ACT_INIT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SYNC = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EDGE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [VTX_W-1:0] src_vertex;
        logic [VTX_W-1:0] dst_vertex;
    } item_t;

    typedef struct packed {
        logic             activated;
        logic             lowered;
        logic [LBL_W-1:0] label_out;
    } result_t;

    // Write command toward the label stores
    typedef struct packed {
        logic             lbl_we;
        logic             prev_we;
        logic [VTX_W-1:0] vertex;
        logic [LBL_W-1:0] lbl_data;
        logic [LBL_W-1:0] prev_data;
    } wr_cmd_t;

    // Registered read data from the label stores
    typedef struct packed {
        logic [LBL_W-1:0] lbl_src;
        logic [LBL_W-1:0] lbl_dst;
        logic [LBL_W-1:0] prev_dst;
    } rd_data_t;

endpackage

// File: sv/mle_store.sv
// Label and previous-label memories with registered reads.
// Label memory has two read ports and one write port; previous-label memory one of each.
// Depends on mle_pkg.
module mle_store
    import mle_pkg::*;
#(
    parameter int unsigned DEPTH = 65536
)
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [VTX_W-1:0]     rd_src,
    input  logic [VTX_W-1:0]     rd_dst,
    output rd_data_t             rd_data,
    input  wr_cmd_t              wr_cmd
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [LBL_W-1:0] lbl_mem  [DEPTH];
    logic [LBL_W-1:0] prev_mem [DEPTH];

    rd_data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg.lbl_src  <= lbl_mem[rd_src[ADDR_W-1:0]];
            rd_data_reg.lbl_dst  <= lbl_mem[rd_dst[ADDR_W-1:0]];
            rd_data_reg.prev_dst <= prev_mem[rd_dst[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cmd.lbl_we)
        begin
            lbl_mem[wr_cmd.vertex[ADDR_W-1:0]] <= wr_cmd.lbl_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cmd.prev_we)
        begin
            prev_mem[wr_cmd.vertex[ADDR_W-1:0]] <= wr_cmd.prev_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/mle_relax.sv
// Modify step of the read-modify-write: decides the result item and the write-back.
// Combinational; fed by the registered item and the store read data.
// Depends on mle_pkg.
module mle_relax
    import mle_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 65536
)
(
    input  item_t    item,
    input  rd_data_t rd_data,
    output result_t  result,
    output wr_cmd_t  wr_cmd
);

    logic src_ok;
    logic dst_ok;
    logic lower;

    assign src_ok = {16'b0, item.src_vertex} < 32'(MAX_VERTICES);
    assign dst_ok = {16'b0, item.dst_vertex} < 32'(MAX_VERTICES);
    assign lower  = src_ok && (rd_data.lbl_src < rd_data.lbl_dst);

    always_comb
    begin
        result           = '0;
        wr_cmd           = '0;
        wr_cmd.vertex    = item.dst_vertex;
        wr_cmd.lbl_data  = item.dst_vertex;
        wr_cmd.prev_data = item.dst_vertex;
        if (dst_ok)
        begin
            result.label_out = rd_data.lbl_dst;
            unique case (item.action)
                ACT_INIT:
                begin
                    wr_cmd.lbl_we    = 1'b1;
                    wr_cmd.prev_we   = 1'b1;
                    result.label_out = item.dst_vertex;
                end
                ACT_SYNC:
                begin
                    wr_cmd.prev_we   = 1'b1;
                    wr_cmd.prev_data = rd_data.lbl_dst;
                end
                ACT_EDGE:
                begin
                    if (lower)
                    begin
                        wr_cmd.lbl_we    = 1'b1;
                        wr_cmd.lbl_data  = rd_data.lbl_src;
                        result.lowered   = 1'b1;
                        result.activated = (rd_data.lbl_dst == rd_data.prev_dst);
                        result.label_out = rd_data.lbl_src;
                    end
                end
                ACT_READ:
                begin
                    result.label_out = rd_data.lbl_dst;
                end
                default:
                begin
                    result.label_out = rd_data.lbl_dst;
                end
            endcase
        end
    end

endmodule

// File: sv/min_label_edge_relax.sv
// Min-label edge relax for label-propagation connected components.
// Memory read is registered on the accept edge; modify and write-back land on the retire edge,
// which may wait on the output; a new item is taken only once the one in flight retires.
// Reset (rst_n, async, active low) clears the sequencer and output valid only;
// label memories are undefined until an init action writes an entry.
module min_label_edge_relax
    import mle_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 65536
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // Store depth: vertex fields are 16 bits, so no more than 2^16 entries are reachable
    localparam int unsigned DEPTH = (MAX_VERTICES < 65536) ? MAX_VERTICES : 65536;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic     state_reg;
    logic     state_next;
    item_t    item_reg;
    result_t  result_reg;
    logic     result_valid_reg;
    logic     result_valid_next;

    logic     accept;
    logic     retire;
    rd_data_t rd_data;
    result_t  relax_result;
    wr_cmd_t  relax_wr;
    wr_cmd_t  store_wr;

    // Take a new item only when no item is in flight; the read starts on the accept edge
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    // Retire the item in flight once the output register is free or being emptied
    assign retire = (state_reg == ST_EXEC) && (!result_valid_reg || result_ready);

    mle_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_src  (item.src_vertex),
        .rd_dst  (item.dst_vertex),
        .rd_data (rd_data),
        .wr_cmd  (store_wr)
    );

    mle_relax #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_relax (
        .item    (item_reg),
        .rd_data (rd_data),
        .result  (relax_result),
        .wr_cmd  (relax_wr)
    );

    // Gate the write-back so it lands exactly once, on the retire edge
    always_comb
    begin
        store_wr         = relax_wr;
        store_wr.lbl_we  = relax_wr.lbl_we && retire;
        store_wr.prev_we = relax_wr.prev_we && retire;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (retire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        priority if (retire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Hold the accepted item for the modify step; load the output on retire
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (retire)
        begin
            result_reg <= relax_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: bench/min_label_edge_relax_tb.sv
// Self-checking testbench for min_label_edge_relax: directed table, then random relax rounds.
// Depends on mle_pkg (item_t, result_t, action codes) and the min_label_edge_relax RTL.
`timescale 1ns / 1ps

module min_label_edge_relax_tb;
    import mle_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int DIR_ROWS        = 24;
    localparam int RAND_ITEMS      = 1250;
    localparam int HOLD_OFF_START  = 1500;   // receiver cycle at which the long stall begins
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;     // leave room after the last result
    localparam int LIMIT_CYCLES    = 200000;

    localparam logic [15:0] STALL_PATTERN = 16'b1011_0111_0010_1101;

    // One row of the directed table: the item, and the result when it is typed in
    typedef struct packed {
        item_t   stim;
        logic    typed;
        result_t want;
    } dir_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    min_label_edge_relax dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow label stores. Only vertices that an init has touched are ever
    // addressed, so the contents of untouched entries never matter.
    // ------------------------------------------------------------------
    logic [LBL_W-1:0] label_copy [0:65535];
    logic [LBL_W-1:0] prev_copy  [0:65535];

    result_t          relax_results_q [$];   // expected results, oldest first
    logic [VTX_W-1:0] work_set [$];          // initialized vertices of the current component set
    dir_row_t         dir_tab [0:DIR_ROWS-1];

    int      error_cnt    = 0;
    int      items_sent   = 0;
    int      checked_cnt  = 0;
    int      lowered_cnt  = 0;
    int      activate_cnt = 0;
    int      round_cnt    = 0;
    int      cycle_cnt    = 0;
    int      burst_left   = 0;
    int      ready_cycle  = 0;
    result_t head_want;

    // Apply one item to the shadow stores and return the result it should produce.
    function automatic result_t relax_predict(input item_t it);
        result_t          res;
        logic [LBL_W-1:0] old_lbl;
        logic [LBL_W-1:0] cand;
        res = '0;
        case (it.action)
            ACT_INIT:
            begin
                label_copy[it.dst_vertex] = it.dst_vertex;
                prev_copy[it.dst_vertex]  = it.dst_vertex;
            end
            ACT_SYNC:
            begin
                prev_copy[it.dst_vertex] = label_copy[it.dst_vertex];
            end
            ACT_EDGE:
            begin
                old_lbl = label_copy[it.dst_vertex];
                cand    = label_copy[it.src_vertex];
                // Strictly smaller only, so a self edge never lowers
                if (cand < old_lbl)
                begin
                    label_copy[it.dst_vertex] = cand;
                    res.lowered = 1'b1;
                    // First lowering since the last sync puts the vertex on the frontier
                    res.activated = (old_lbl == prev_copy[it.dst_vertex]);
                end
            end
            default:
            begin
            end
        endcase
        res.label_out = label_copy[it.dst_vertex];
        return res;
    endfunction

    function automatic dir_row_t mk_row(input logic [ACT_W-1:0] act, input logic [15:0] src,
                                        input logic [15:0] dst, input logic typed,
                                        input logic actv, input logic low,
                                        input logic [15:0] lbl);
        dir_row_t row;
        row.stim.action     = act;
        row.stim.src_vertex = src;
        row.stim.dst_vertex = dst;
        row.typed           = typed;
        row.want.activated  = actv;
        row.want.lowered    = low;
        row.want.label_out  = lbl;
        return row;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s on result %0d at %0t: got %h, want %h",
                 field, checked_cnt, $realtime, got, want);
        error_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Sender: present one item, hold it until accepted, then record the
    // expected result. Bursts of random length are separated by random gaps;
    // now and then a long burst runs with no gaps at all.
    // ------------------------------------------------------------------
    task automatic send_item(input item_t it, input logic typed, input result_t want);
        int      gap;
        result_t predicted;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(40, 120);
            end
            else
            begin
                gap        = $urandom_range(0, 8);
                burst_left = $urandom_range(1, 24);
            end
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= it;
        // Hold valid and payload until the handshake edge
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        items_sent++;
        predicted = relax_predict(it);
        if (predicted.lowered)
            lowered_cnt++;
        if (predicted.activated)
            activate_cnt++;
        relax_results_q.push_back(typed ? want : predicted);
    endtask

    function automatic logic [VTX_W-1:0] pick_vertex();
        return work_set[$urandom_range(0, work_set.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // One propagation round: maybe start a fresh component set with inits,
    // sync every vertex of the set, then stream edges among the set with a
    // sprinkle of reads, stray syncs and re-inits.
    // ------------------------------------------------------------------
    task automatic run_round();
        item_t it;
        int    n_new;
        int    n_edges;
        int    pick;
        if (work_set.size() < 4 || $urandom_range(0, 5) == 0)
        begin
            work_set.delete();
            n_new = $urandom_range(4, 14);
            repeat (n_new)
            begin
                it.action     = ACT_INIT;
                it.src_vertex = 16'($urandom);
                it.dst_vertex = 16'($urandom);
                send_item(it, 1'b0, '0);
                work_set.push_back(it.dst_vertex);
            end
        end
        foreach (work_set[i])
        begin
            it.action     = ACT_SYNC;
            it.src_vertex = 16'($urandom);
            it.dst_vertex = work_set[i];
            send_item(it, 1'b0, '0);
        end
        n_edges = $urandom_range(16, 40);
        repeat (n_edges)
        begin
            pick          = $urandom_range(0, 99);
            it.dst_vertex = pick_vertex();
            // src is ignored outside edges; give it any value
            it.src_vertex = $urandom_range(0, 1) ? 16'($urandom) : pick_vertex();
            if (pick < 80)
            begin
                it.action     = ACT_EDGE;
                it.src_vertex = ($urandom_range(0, 11) == 0) ? it.dst_vertex : pick_vertex();
            end
            else if (pick < 90)
                it.action = ACT_READ;
            else if (pick < 95)
                it.action = ACT_SYNC;
            else
                it.action = ACT_INIT;   // raises the label back and resets the round mark
            send_item(it, 1'b0, '0);
        end
        round_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset once, walk the directed table, run random rounds,
    // drain, then report.
    // ------------------------------------------------------------------
    initial
    begin
        dir_tab = '{
            // Init the extremes and the alternating patterns
            mk_row(ACT_INIT, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_INIT, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'hFFFF),
            mk_row(ACT_INIT, 16'h1234, 16'h0001, 1'b1, 1'b0, 1'b0, 16'h0001),
            mk_row(ACT_INIT, 16'hAAAA, 16'h5555, 1'b1, 1'b0, 1'b0, 16'h5555),
            mk_row(ACT_INIT, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b0, 16'hAAAA),
            mk_row(ACT_READ, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'hFFFF),
            mk_row(ACT_READ, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000),
            // Smallest label onto the largest vertex, fresh round: lowered and activated
            mk_row(ACT_EDGE, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'h0000),
            mk_row(ACT_EDGE, 16'h0001, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0000),
            // Self edges never lower
            mk_row(ACT_EDGE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_EDGE, 16'h5555, 16'h5555, 1'b1, 1'b0, 1'b0, 16'h5555),
            // Two lowerings in one round: only the first activates
            mk_row(ACT_EDGE, 16'h0001, 16'hAAAA, 1'b0, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_EDGE, 16'h0000, 16'hAAAA, 1'b0, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_SYNC, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_EDGE, 16'h5555, 16'h0001, 1'b0, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_EDGE, 16'h0001, 16'h5555, 1'b0, 1'b0, 1'b0, 16'h0000),
            // After a sync the next lowering activates again
            mk_row(ACT_SYNC, 16'h0000, 16'h5555, 1'b0, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_EDGE, 16'h0000, 16'h5555, 1'b0, 1'b0, 1'b0, 16'h0000),
            // Re-init raises the label back to the vertex index
            mk_row(ACT_INIT, 16'h0000, 16'h5555, 1'b1, 1'b0, 1'b0, 16'h5555),
            mk_row(ACT_READ, 16'h1234, 16'h5555, 1'b1, 1'b0, 1'b0, 16'h5555),
            mk_row(ACT_EDGE, 16'hFFFF, 16'h0001, 1'b0, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_READ, 16'h0000, 16'h0001, 1'b0, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_SYNC, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0000),
            mk_row(ACT_EDGE, 16'hAAAA, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_item(dir_tab[r].stim, dir_tab[r].typed, dir_tab[r].want);

        // Carry the directed vertices into the first random round
        work_set = '{16'h0000, 16'h0001, 16'h5555, 16'hAAAA, 16'hFFFF};
        while (items_sent < DIR_ROWS + RAND_ITEMS)
            run_round();

        item_valid <= 1'b0;
        while (relax_results_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d items (%0d directed, %0d random rounds), %0d results checked",
                 items_sent, DIR_ROWS, round_cnt, checked_cnt);
        $display("Summary: %0d edges lowered a label, %0d activated a vertex, %0d-cycle stall",
                 lowered_cnt, activate_cnt, HOLD_OFF_CYCLES);
        if (error_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a randomly re-picked mode (always ready,
    // random, fixed pattern, mostly stalled). Once, hold ready low for a long
    // stretch so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int  mode;
        bit  hold_done;
        mode      = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            ready_cycle++;
            if (ready_cycle % 64 == 0)
                mode = $urandom_range(0, 3);
            if (!hold_done && ready_cycle >= HOLD_OFF_START)
            begin
                hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 9) < 6);
                    2:       result_ready <= STALL_PATTERN[ready_cycle % 16];
                    default: result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (relax_results_q.size() == 0)
                report_mismatch("unexpected result, label", result.label_out, 16'h0000);
            else
            begin
                head_want = relax_results_q.pop_front();
                if (result.activated !== head_want.activated)
                    report_mismatch("activated", 16'(result.activated),
                                    16'(head_want.activated));
                if (result.lowered !== head_want.lowered)
                    report_mismatch("lowered", 16'(result.lowered), 16'(head_want.lowered));
                if (result.label_out !== head_want.label_out)
                    report_mismatch("label_out", result.label_out, head_want.label_out);
            end
            checked_cnt++;
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_cnt, relax_results_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

// File: min_label_edge_relax.f
sv/mle_pkg.sv
sv/mle_store.sv
sv/mle_relax.sv
sv/min_label_edge_relax.sv
bench/min_label_edge_relax_tb.sv
